FILE: hdl/pattern_rect_fill_rop_top_assert.svh
// Assertion macros shared by the pattern fill raster-op block.
`ifndef PATTERN_RECT_FILL_ROP_TOP_ASSERT_SVH
`define PATTERN_RECT_FILL_ROP_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PRFR_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("prfr assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PRFR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("prfr assertion failed");

`endif

FILE: hdl/prfr_pkg.sv
// Types and constants of the pattern fill raster-op block.
`timescale 1ns / 1ps

package prfr_pkg;

    localparam int PIX_W          = 32;
    localparam int ADDR_W         = 32;
    localparam int PATTERN_W      = 64;
    localparam int BASE_W         = 30;
    localparam int PITCH_W        = 14;
    localparam int PHASE_W        = 3;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_W     = 64;

    typedef enum logic [1:0] {
        MODE_COPY = 2'd0,
        MODE_OR   = 2'd1,
        MODE_AND  = 2'd2,
        MODE_XOR  = 2'd3
    } fill_mode_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_PATTERN_BITS = 3'd0,
        REG_FORE_PIXEL   = 3'd1,
        REG_BACK_PIXEL   = 3'd2,
        REG_PHASE_X      = 3'd3,
        REG_PHASE_Y      = 3'd4,
        REG_FILL_MODE    = 3'd5,
        REG_FRAME_BASE   = 3'd6,
        REG_ROW_PITCH    = 3'd7
    } cfg_index_t;

    // Settings the raster-op stage needs.
    typedef struct packed {
        fill_mode_t         mode;
        logic [PIX_W-1:0]   fore;
        logic [PIX_W-1:0]   back;
        logic               pattern_full;
    } rop_cfg_t;

endpackage

FILE: hdl/pattern_rect_fill_rop_top.sv
// Top level of the 8x8 pattern rectangle fill raster-op engine.
//
//   channel  direction  tdata (low bit up)                    tuser
//   s_       in         pixel_x, pixel_y, dest_pixel          -
//   m_       out        new_pixel, word_address               write_enable
//   cfg_     in         plain write: index, 64-bit data       -
//
// One pixel is accepted every clock unless every stage is full and the output
// is stalled. The pipeline has three stages: pattern index, pattern lookup
// with the y*pitch multiply, then raster op and address add. A stalled output
// holds its stage; earlier stages keep filling bubbles.
// aresetn is synchronous; it clears the valid bits and resets the config registers.
`timescale 1ns / 1ps

`include "pattern_rect_fill_rop_top_assert.svh"

module pattern_rect_fill_rop_top #(
    parameter int COORD_BITS = 12,
    parameter int PIXEL_BITS = 32
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // pixel_x, pixel_y, dest_pixel, zero pad
    input  logic [((2*COORD_BITS+PIXEL_BITS+7)/8)*8-1:0] s_tdata,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // new_pixel, word_address
    output logic [PIXEL_BITS+prfr_pkg::ADDR_W-1:0]  m_tdata,
    // write_enable
    output logic                                    m_tuser,
    input  logic                                    cfg_wr_en,
    input  logic [prfr_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [prfr_pkg::CFG_DATA_W-1:0]         cfg_wdata
);

    localparam int PROD_W = COORD_BITS + prfr_pkg::PITCH_W;
    localparam int X_LO   = 0;
    localparam int Y_LO   = COORD_BITS;
    localparam int D_LO   = 2 * COORD_BITS;

    // Configuration registers.
    logic [prfr_pkg::PATTERN_W-1:0] pattern_reg, pattern_next;
    logic                           pattern_full_reg, pattern_full_next;
    logic [PIXEL_BITS-1:0]          fore_reg, fore_next;
    logic [PIXEL_BITS-1:0]          back_reg, back_next;
    logic [prfr_pkg::PHASE_W-1:0]   phase_x_reg, phase_x_next;
    logic [prfr_pkg::PHASE_W-1:0]   phase_y_reg, phase_y_next;
    prfr_pkg::fill_mode_t           mode_reg, mode_next;
    logic [prfr_pkg::BASE_W-1:0]    base_reg, base_next;
    logic [prfr_pkg::PITCH_W-1:0]   pitch_reg, pitch_next;

    always_comb begin
        pattern_next      = pattern_reg;
        pattern_full_next = pattern_full_reg;
        fore_next         = fore_reg;
        back_next         = back_reg;
        phase_x_next      = phase_x_reg;
        phase_y_next      = phase_y_reg;
        mode_next         = mode_reg;
        base_next         = base_reg;
        pitch_next        = pitch_reg;
        if (cfg_wr_en) begin
            case (prfr_pkg::cfg_index_t'(cfg_index))
                prfr_pkg::REG_PATTERN_BITS: begin
                    pattern_next      = cfg_wdata;
                    pattern_full_next = &cfg_wdata;
                end
                prfr_pkg::REG_FORE_PIXEL: fore_next    = cfg_wdata[PIXEL_BITS-1:0];
                prfr_pkg::REG_BACK_PIXEL: back_next    = cfg_wdata[PIXEL_BITS-1:0];
                prfr_pkg::REG_PHASE_X:    phase_x_next = cfg_wdata[prfr_pkg::PHASE_W-1:0];
                prfr_pkg::REG_PHASE_Y:    phase_y_next = cfg_wdata[prfr_pkg::PHASE_W-1:0];
                prfr_pkg::REG_FILL_MODE:  mode_next    = prfr_pkg::fill_mode_t'(cfg_wdata[1:0]);
                prfr_pkg::REG_FRAME_BASE: base_next    = cfg_wdata[prfr_pkg::BASE_W-1:0];
                prfr_pkg::REG_ROW_PITCH:  pitch_next   = cfg_wdata[prfr_pkg::PITCH_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg      <= '1;
            pattern_full_reg <= 1'b1;
            fore_reg         <= '0;
            back_reg         <= '1;
            phase_x_reg      <= '0;
            phase_y_reg      <= '0;
            mode_reg         <= prfr_pkg::MODE_COPY;
            base_reg         <= '0;
            pitch_reg        <= '0;
        end else begin
            pattern_reg      <= pattern_next;
            pattern_full_reg <= pattern_full_next;
            fore_reg         <= fore_next;
            back_reg         <= back_next;
            phase_x_reg      <= phase_x_next;
            phase_y_reg      <= phase_y_next;
            mode_reg         <= mode_next;
            base_reg         <= base_next;
            pitch_reg        <= pitch_next;
        end
    end

    // Stage handshake: a stage loads when it is empty or its successor loads.
    logic s1_valid_reg, s2_valid_reg, m_valid_reg;
    logic s1_ready, s2_ready, s3_ready;

    assign s3_ready = !m_valid_reg || m_tready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s_tready = s1_ready;

    // Stage 1: input capture and pattern bit index.
    logic [COORD_BITS-1:0] s1_x_reg, s1_y_reg;
    logic [PIXEL_BITS-1:0] s1_dest_reg;
    logic [5:0]            s1_idx_reg, s1_idx_next;
    logic [2:0]            row_sum, col_sum;

    assign row_sum = s_tdata[Y_LO +: 3] + phase_y_reg;
    assign col_sum = s_tdata[X_LO +: 3] + phase_x_reg;
    // Bit 7-col of byte row sits at row*8 + (7-col).
    assign s1_idx_next = {row_sum, ~col_sum};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_ready) begin
            s1_valid_reg <= s_tvalid;
        end
        if (s1_ready && s_tvalid) begin
            s1_x_reg    <= s_tdata[X_LO +: COORD_BITS];
            s1_y_reg    <= s_tdata[Y_LO +: COORD_BITS];
            s1_dest_reg <= s_tdata[D_LO +: PIXEL_BITS];
            s1_idx_reg  <= s1_idx_next;
        end
    end

    // Stage 2: pattern lookup and row offset multiply.
    logic [COORD_BITS-1:0] s2_x_reg;
    logic [PIXEL_BITS-1:0] s2_dest_reg;
    logic                  s2_bit_reg;
    logic [PROD_W-1:0]     s2_prod_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_ready) begin
            s2_valid_reg <= s1_valid_reg;
        end
        if (s2_ready && s1_valid_reg) begin
            s2_x_reg    <= s1_x_reg;
            s2_dest_reg <= s1_dest_reg;
            s2_bit_reg  <= pattern_reg[s1_idx_reg];
            s2_prod_reg <= PROD_W'(s1_y_reg) * PROD_W'(pitch_reg);
        end
    end

    // Stage 3: raster op and address add into the output register.
    prfr_pkg::rop_cfg_t     rop_cfg;
    logic                   rop_we;
    logic [PIXEL_BITS-1:0]  rop_pix;
    logic [prfr_pkg::ADDR_W-1:0] addr_next;

    assign rop_cfg.mode         = mode_reg;
    assign rop_cfg.fore         = fore_reg;
    assign rop_cfg.back         = back_reg;
    assign rop_cfg.pattern_full = pattern_full_reg;

    prfr_rop u_rop (
        .cfg     (rop_cfg),
        .pat_bit (s2_bit_reg),
        .dest    (s2_dest_reg),
        .we      (rop_we),
        .pix     (rop_pix)
    );

    assign addr_next = prfr_pkg::ADDR_W'(base_reg) + prfr_pkg::ADDR_W'(s2_prod_reg)
                     + prfr_pkg::ADDR_W'(s2_x_reg);

    logic                        m_we_reg;
    logic [PIXEL_BITS-1:0]       m_pix_reg;
    logic [prfr_pkg::ADDR_W-1:0] m_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s3_ready) begin
            m_valid_reg <= s2_valid_reg;
        end
        if (s3_ready && s2_valid_reg) begin
            m_we_reg   <= rop_we;
            m_pix_reg  <= rop_pix;
            m_addr_reg <= addr_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_we_reg;
    assign m_tdata  = {m_addr_reg, m_pix_reg};

    // An accepted request always lands in the first stage.
    `PRFR_ASSERT_NEXT(a_accept_fills_s1, aclk, aresetn, s_tvalid && s_tready, s1_valid_reg)
    // A blocked first stage keeps its item.
    `PRFR_ASSERT_NEXT(a_s1_holds, aclk, aresetn, s1_valid_reg && !s2_ready,
                      s1_valid_reg && $stable(s1_dest_reg) && $stable(s1_idx_reg))
    // A blocked second stage keeps its item.
    `PRFR_ASSERT_NEXT(a_s2_holds, aclk, aresetn, s2_valid_reg && !s3_ready,
                      s2_valid_reg && $stable(s2_prod_reg) && $stable(s2_bit_reg))
    // The input side can only stall when every stage is full.
    `PRFR_ASSERT_NOW(a_stall_needs_full, aclk, aresetn, !s_tready,
                     s1_valid_reg && s2_valid_reg && m_valid_reg && !m_tready)

endmodule

FILE: hdl/prfr_rop.sv
// Raster-op combine of foreground, background and destination words.
`timescale 1ns / 1ps

module prfr_rop (
    input  prfr_pkg::rop_cfg_t            cfg,
    input  logic                          pat_bit,
    input  logic [prfr_pkg::PIX_W-1:0]    dest,
    output logic                          we,
    output logic [prfr_pkg::PIX_W-1:0]    pix
);

    always_comb begin
        we  = 1'b0;
        pix = dest;
        case (cfg.mode)
            prfr_pkg::MODE_COPY: begin
                we  = 1'b1;
                pix = pat_bit ? cfg.fore : cfg.back;
            end
            prfr_pkg::MODE_OR: begin
                if (pat_bit) begin
                    we  = 1'b1;
                    pix = cfg.fore;
                end
            end
            prfr_pkg::MODE_AND: begin
                // A solid pattern fills the whole rectangle with the background.
                if (cfg.pattern_full || !pat_bit) begin
                    we  = 1'b1;
                    pix = cfg.back;
                end
            end
            prfr_pkg::MODE_XOR: begin
                if (pat_bit) begin
                    we  = 1'b1;
                    pix = ~dest;
                end
            end
            default: begin
                we  = 1'b0;
                pix = dest;
            end
        endcase
    end

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the 8x8 pattern rectangle fill raster-op engine.
`timescale 1ns / 1ps

module testbench;

    localparam int COORD_BITS  = 12;
    localparam int S_DATA_W    = ((2*COORD_BITS+32+7)/8)*8;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        logic        we;
        logic [31:0] pix;
        logic [31:0] addr;
    } pixel_write_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [63:0]           m_tdata;
    logic                  m_tuser;
    logic                  cfg_wr_en = 1'b0;
    logic [2:0]            cfg_index = '0;
    logic [63:0]           cfg_wdata = '0;

    // Shadow copy of the block's registers.
    logic [63:0]           pat_rows;
    logic [31:0]           fore_word;
    logic [31:0]           back_word;
    logic [2:0]            pat_phase_x;
    logic [2:0]            pat_phase_y;
    prfr_pkg::fill_mode_t  cur_mode;
    logic [29:0]           frame_base;
    logic [13:0]           row_pitch;

    pixel_write_t pending_writes[$];
    int unsigned  mismatch_count = 0;
    int unsigned  quiet_cycles = 0;
    bit           tx_idle_on = 1'b1;
    bit           rx_idle_on = 1'b1;
    logic         hold_request = 1'b0;
    logic         hold_done = 1'b0;
    int unsigned  hold_left = 0;

    pattern_rect_fill_rop_top #(.COORD_BITS(COORD_BITS), .PIXEL_BITS(32)) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #10 aclk = ~aclk;

    function automatic pixel_write_t predict_pixel_write(logic [11:0] x, logic [11:0] y,
                                                         logic [31:0] dest);
        logic [2:0]   row;
        logic [2:0]   col;
        logic         pat_bit;
        pixel_write_t w;
        row = y[2:0] + pat_phase_y;
        col = x[2:0] + pat_phase_x;
        // Column 0 of a row is the most significant bit of its byte.
        pat_bit = pat_rows[{row, 3'd7 - col}];
        w.we  = 1'b0;
        w.pix = dest;
        case (cur_mode)
            prfr_pkg::MODE_COPY: begin
                w.we  = 1'b1;
                w.pix = pat_bit ? fore_word : back_word;
            end
            prfr_pkg::MODE_OR: if (pat_bit) begin
                w.we  = 1'b1;
                w.pix = fore_word;
            end
            prfr_pkg::MODE_AND: if (pat_rows == '1 || !pat_bit) begin
                w.we  = 1'b1;
                w.pix = back_word;
            end
            prfr_pkg::MODE_XOR: if (pat_bit) begin
                w.we  = 1'b1;
                w.pix = ~dest;
            end
            default: ;
        endcase
        w.addr = 32'(frame_base) + 32'(y) * 32'(row_pitch) + 32'(x);
        return w;
    endfunction

    task automatic write_reg(prfr_pkg::cfg_index_t idx, logic [63:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (idx)
            prfr_pkg::REG_PATTERN_BITS: pat_rows    = value;
            prfr_pkg::REG_FORE_PIXEL:   fore_word   = value[31:0];
            prfr_pkg::REG_BACK_PIXEL:   back_word   = value[31:0];
            prfr_pkg::REG_PHASE_X:      pat_phase_x = value[2:0];
            prfr_pkg::REG_PHASE_Y:      pat_phase_y = value[2:0];
            prfr_pkg::REG_FILL_MODE:    cur_mode    = prfr_pkg::fill_mode_t'(value[1:0]);
            prfr_pkg::REG_FRAME_BASE:   frame_base  = value[29:0];
            prfr_pkg::REG_ROW_PITCH:    row_pitch   = value[13:0];
            default: ;
        endcase
    endtask

    // Random upper bits check that the block keeps only the register's width.
    function automatic logic [63:0] with_junk(logic [63:0] low_value, int width);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        return (junk << width) | low_value;
    endfunction

    task automatic send_pixel(logic [11:0] x, logic [11:0] y, logic [31:0] dest);
        while (tx_idle_on && $urandom_range(99) < 32) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {dest, y, x};
        do @(posedge aclk); while (!s_tready);
        pending_writes.push_back(predict_pixel_write(x, y, dest));
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        while (pending_writes.size() != 0) @(posedge aclk);
    endtask

    task automatic test_reset_defaults();
        send_pixel(12'd0, 12'd0, 32'h0000_0000);
        send_pixel(12'hfff, 12'hfff, 32'hffff_ffff);
        wait_for_drain();
    endtask

    task automatic test_directed_modes();
        write_reg(prfr_pkg::REG_PATTERN_BITS, 64'h55aa_33cc_f00f_8001);
        write_reg(prfr_pkg::REG_FORE_PIXEL, with_junk(64'ha5a5_a5a5, 32));
        write_reg(prfr_pkg::REG_BACK_PIXEL, with_junk(64'h5a5a_5a5a, 32));
        write_reg(prfr_pkg::REG_PHASE_X, with_junk(64'd3, 3));
        write_reg(prfr_pkg::REG_PHASE_Y, with_junk(64'd7, 3));
        write_reg(prfr_pkg::REG_FRAME_BASE, with_junk(64'h3fff_ffff, 30));
        write_reg(prfr_pkg::REG_ROW_PITCH, with_junk(64'h3fff, 14));
        for (int m = 0; m < 4; m++) begin
            write_reg(prfr_pkg::REG_FILL_MODE, with_junk(64'(m), 2));
            send_pixel(12'd0, 12'd0, 32'h0000_0000);
            send_pixel(12'hfff, 12'hfff, 32'hffff_ffff);
            send_pixel(12'd7, 12'd1, $urandom);
            send_pixel(12'($urandom), 12'($urandom), $urandom);
            wait_for_drain();
        end
        // An all-ones pattern in and mode fills with the background word.
        write_reg(prfr_pkg::REG_PATTERN_BITS, '1);
        write_reg(prfr_pkg::REG_FILL_MODE, 64'(prfr_pkg::MODE_AND));
        send_pixel(12'd0, 12'd0, 32'h1234_5678);
        send_pixel(12'd5, 12'd3, 32'hdead_beef);
        send_pixel(12'hfff, 12'd0, 32'h0000_0000);
        wait_for_drain();
        // An empty pattern in and mode also writes the background everywhere.
        write_reg(prfr_pkg::REG_PATTERN_BITS, '0);
        send_pixel(12'd1, 12'd2, 32'hffff_ffff);
        send_pixel(12'd6, 12'hffe, 32'h0f0f_0f0f);
        wait_for_drain();
    endtask

    task automatic randomize_settings(int phase);
        logic [63:0] pattern;
        case ($urandom_range(4))
            0:       pattern = '1;
            1:       pattern = '0;
            2:       pattern = 64'hff << (8 * $urandom_range(7));
            default: pattern = {$urandom, $urandom};
        endcase
        if (phase == 0) pattern = '1;
        if (phase == 1) pattern = '0;
        write_reg(prfr_pkg::REG_PATTERN_BITS, pattern);
        write_reg(prfr_pkg::REG_FORE_PIXEL, ($urandom_range(3) == 0) ? with_junk('0, 32)
                                                           : {$urandom, $urandom});
        write_reg(prfr_pkg::REG_BACK_PIXEL,
                  ($urandom_range(3) == 0) ? with_junk(64'hffff_ffff, 32)
                                           : {$urandom, $urandom});
        write_reg(prfr_pkg::REG_PHASE_X, {$urandom, $urandom});
        write_reg(prfr_pkg::REG_PHASE_Y, {$urandom, $urandom});
        write_reg(prfr_pkg::REG_FILL_MODE, with_junk(64'(phase % 4), 2));
        if (phase == 2) begin
            write_reg(prfr_pkg::REG_FRAME_BASE, with_junk(64'h3fff_ffff, 30));
            write_reg(prfr_pkg::REG_ROW_PITCH, with_junk(64'h3fff, 14));
        end else if (phase == 3) begin
            write_reg(prfr_pkg::REG_FRAME_BASE, with_junk('0, 30));
            write_reg(prfr_pkg::REG_ROW_PITCH, with_junk('0, 14));
        end else begin
            write_reg(prfr_pkg::REG_FRAME_BASE, {$urandom, $urandom});
            write_reg(prfr_pkg::REG_ROW_PITCH, {$urandom, $urandom});
        end
    endtask

    // Mostly small rectangles walked in raster order, with stray pixels between them.
    task automatic fill_rectangles(int pixel_goal);
        int sent;
        int w;
        int h;
        int x0;
        int y0;
        sent = 0;
        while (sent < pixel_goal) begin
            if ($urandom_range(99) < 15) begin
                send_pixel(12'($urandom), 12'($urandom), $urandom);
                sent++;
            end else begin
                w  = $urandom_range(20, 1);
                h  = $urandom_range(8, 1);
                x0 = $urandom_range(4096 - w, 0);
                y0 = $urandom_range(4096 - h, 0);
                for (int j = 0; j < h && sent < pixel_goal; j++) begin
                    for (int i = 0; i < w && sent < pixel_goal; i++) begin
                        send_pixel(12'(x0 + i), 12'(y0 + j), $urandom);
                        sent++;
                    end
                end
            end
        end
    endtask

    task automatic test_random_fill();
        for (int phase = 0; phase < 12; phase++) begin
            randomize_settings(phase);
            tx_idle_on = (phase != 5);
            rx_idle_on = (phase != 5);
            fill_rectangles(140);
            wait_for_drain();
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // The receiver stops for a long stretch while pixels keep coming.
    task automatic test_backpressure();
        randomize_settings($urandom_range(3));
        tx_idle_on = 1'b0;
        hold_request <= 1'b1;
        fill_rectangles(60);
        tx_idle_on = 1'b1;
        wait_for_drain();
    endtask

    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (hold_request && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= !(rx_idle_on && $urandom_range(99) < 32);
        end
    end

    always @(posedge aclk) begin
        pixel_write_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_writes.size() == 0) begin
                $display("%0t: unexpected result we=%0b pix=%h addr=%h", $time,
                         m_tuser, m_tdata[31:0], m_tdata[63:32]);
                mismatch_count++;
            end else begin
                want = pending_writes.pop_front();
                if (m_tuser !== want.we) begin
                    $display("%0t: write_enable expected %0b actual %0b", $time,
                             want.we, m_tuser);
                    mismatch_count++;
                end
                if (m_tdata[31:0] !== want.pix) begin
                    $display("%0t: new_pixel expected %h actual %h", $time,
                             want.pix, m_tdata[31:0]);
                    mismatch_count++;
                end
                if (m_tdata[63:32] !== want.addr) begin
                    $display("%0t: word_address expected %h actual %h", $time,
                             want.addr, m_tdata[63:32]);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("pattern_rect_fill_rop_top: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        pat_rows    = '1;
        fore_word   = '0;
        back_word   = '1;
        pat_phase_x = '0;
        pat_phase_y = '0;
        cur_mode    = prfr_pkg::MODE_COPY;
        frame_base  = '0;
        row_pitch   = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_directed_modes();
        test_random_fill();
        test_backpressure();
        wait_for_drain();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0 && pending_writes.size() == 0) begin
            $display("pattern_rect_fill_rop_top: match");
        end else begin
            $display("pattern_rect_fill_rop_top: mismatch");
        end
        $finish;
    end

endmodule
